// ----- rtl/owdq_pkg.sv -----
// Shared types and constants for the overwrite-oldest descriptor queue.
package owdq_pkg;

  localparam int QUEUE_DEPTH_DEFAULT = 8;
  localparam int FIELD_W = 16;
  localparam int HELD_W = 4;

  typedef enum logic [1:0] {
    OP_PUSH        = 2'd0,
    OP_POP         = 2'd1,
    OP_PEEK_OLDEST = 2'd2,
    OP_PEEK_NEWEST = 2'd3
  } op_t;

  typedef struct packed {
    logic [FIELD_W-1:0] topic;
    logic [FIELD_W-1:0] msg_id;
    logic [FIELD_W-1:0] msg_length;
  } entry_t;

  typedef struct packed {
    logic ok;
    logic show;
  } status_t;

endpackage

// ----- rtl/owdq_if.sv -----
// Request and response channel interfaces of the descriptor queue.
interface owdq_req_if;
  logic                             valid;
  logic                             ready;
  owdq_pkg::op_t                    opcode;
  logic [owdq_pkg::FIELD_W-1:0]     topic;
  logic [owdq_pkg::FIELD_W-1:0]     msg_id;
  logic [owdq_pkg::FIELD_W-1:0]     msg_length;

  modport source (output valid, opcode, topic, msg_id, msg_length, input ready);
  modport sink (input valid, opcode, topic, msg_id, msg_length, output ready);
endinterface

interface owdq_rsp_if;
  logic                             valid;
  logic                             ready;
  logic                             ok;
  logic [owdq_pkg::FIELD_W-1:0]     out_topic;
  logic [owdq_pkg::FIELD_W-1:0]     out_id;
  logic [owdq_pkg::FIELD_W-1:0]     out_length;
  logic [owdq_pkg::HELD_W-1:0]      entries_held;

  modport source (output valid, ok, out_topic, out_id, out_length, entries_held,
                  input ready);
  modport sink (input valid, ok, out_topic, out_id, out_length, entries_held,
                output ready);
endinterface

// ----- rtl/overwrite_oldest_descriptor_queue_top.sv -----
// Top level of the overwrite-oldest descriptor queue.
// Each request word (push, pop, peek oldest or peek newest) yields exactly one
// response word, in the cycle after it is accepted, and a new request is taken in
// every cycle in which the response register is empty or being drained. The
// rate is set by the single pointer update and the one registered read port
// of the descriptor store. Only occupied slots are ever shown, so the store
// needs no clearing after reset. Write keep_oldest_when_full only while the
// queue is idle; when set, a push to a full queue is refused instead of
// dropping the oldest descriptor.
module overwrite_oldest_descriptor_queue_top #(
  parameter int QUEUE_DEPTH = owdq_pkg::QUEUE_DEPTH_DEFAULT,
  localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1,
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_wdata,
  owdq_req_if.sink    req,
  owdq_rsp_if.source  rsp
);

  logic               lock;
  logic               accept;
  logic               wr_en;
  logic [IDX_W-1:0]   wr_addr;
  logic [IDX_W-1:0]   rd_addr;
  owdq_pkg::status_t  status;
  logic [CNT_W-1:0]   count_next;
  owdq_pkg::entry_t   wr_data;
  owdq_pkg::entry_t   rd_data;
  logic               rsp_valid;
  owdq_pkg::status_t  rsp_status;
  logic [CNT_W-1:0]   rsp_count;

  assign req.ready = !rsp_valid || rsp.ready;
  assign accept    = req.valid && req.ready;

  assign wr_data.topic      = req.topic;
  assign wr_data.msg_id     = req.msg_id;
  assign wr_data.msg_length = req.msg_length;

  always_ff @(posedge clk) begin
    if (rst) begin
      lock <= 1'b0;
    end else if (cfg_we) begin
      lock <= cfg_wdata;
    end
  end

  owdq_ctrl #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .opcode     (req.opcode),
    .msg_length (req.msg_length),
    .lock       (lock),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .rd_addr    (rd_addr),
    .status     (status),
    .count_next (count_next)
  );

  owdq_store #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_store (
    .clk     (clk),
    .wr_en   (wr_en && accept),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (accept),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (accept) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp_status <= status;
      rsp_count  <= count_next;
    end
  end

  assign rsp.valid        = rsp_valid;
  assign rsp.ok           = rsp_status.ok;
  assign rsp.out_topic    = rsp_status.show ? rd_data.topic : '0;
  assign rsp.out_id       = rsp_status.show ? rd_data.msg_id : '0;
  assign rsp.out_length   = rsp_status.show ? rd_data.msg_length : '0;
  assign rsp.entries_held = owdq_pkg::HELD_W'(rsp_count);

endmodule

// ----- rtl/owdq_ctrl.sv -----
// Head, tail and fill count of the queue with the per-word operation decode.
module owdq_ctrl #(
  parameter int QUEUE_DEPTH = owdq_pkg::QUEUE_DEPTH_DEFAULT,
  localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1,
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         accept,
  input  owdq_pkg::op_t                opcode,
  input  logic [owdq_pkg::FIELD_W-1:0] msg_length,
  input  logic                         lock,
  output logic                         wr_en,
  output logic [IDX_W-1:0]             wr_addr,
  output logic [IDX_W-1:0]             rd_addr,
  output owdq_pkg::status_t            status,
  output logic [CNT_W-1:0]             count_next
);

  logic [IDX_W-1:0] head;
  logic [IDX_W-1:0] head_next;
  logic [IDX_W-1:0] tail;
  logic [IDX_W-1:0] tail_next;
  logic [CNT_W-1:0] count;
  logic [IDX_W-1:0] head_inc;
  logic [IDX_W-1:0] tail_inc;
  logic [IDX_W-1:0] tail_dec;
  logic             full;
  logic             empty;

  assign head_inc = (head == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : head + IDX_W'(1);
  assign tail_inc = (tail == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : tail + IDX_W'(1);
  assign tail_dec = (tail == '0) ? IDX_W'(QUEUE_DEPTH - 1) : tail - IDX_W'(1);
  assign full     = (count == CNT_W'(QUEUE_DEPTH));
  assign empty    = (count == '0);
  assign wr_addr  = tail;
  assign rd_addr  = (opcode == owdq_pkg::OP_PEEK_NEWEST) ? tail_dec : head;

  always_comb begin
    head_next   = head;
    tail_next   = tail;
    count_next  = count;
    wr_en       = 1'b0;
    status.ok   = 1'b0;
    status.show = 1'b0;
    case (opcode)
      owdq_pkg::OP_PUSH: begin
        if (msg_length != '0 && (!full || !lock)) begin
          wr_en     = 1'b1;
          tail_next = tail_inc;
          status.ok = 1'b1;
          if (full) begin
            head_next = head_inc;
          end else begin
            count_next = count + CNT_W'(1);
          end
        end
      end
      owdq_pkg::OP_POP: begin
        if (!empty) begin
          status.ok   = 1'b1;
          status.show = 1'b1;
          head_next   = head_inc;
          count_next  = count - CNT_W'(1);
        end
      end
      default: begin
        if (!empty) begin
          status.ok   = 1'b1;
          status.show = 1'b1;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else if (accept) begin
      head  <= head_next;
      tail  <= tail_next;
      count <= count_next;
    end
  end

  a_count_bounded: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(QUEUE_DEPTH))
    else $error("fill count exceeds queue depth");

  a_ptrs_meet: assert property (@(posedge clk) disable iff (rst)
    (empty || full) |-> (head == tail))
    else $error("head and tail disagree with an empty or full queue");

  a_pop_decrements: assert property (@(posedge clk) disable iff (rst)
    (accept && opcode == owdq_pkg::OP_POP && !empty) |=> (count == $past(count) - CNT_W'(1)))
    else $error("pop on a nonempty queue did not lower the count");

endmodule

// ----- rtl/owdq_store.sv -----
// Descriptor storage with one write port and one registered read port.
module owdq_store #(
  parameter int QUEUE_DEPTH = owdq_pkg::QUEUE_DEPTH_DEFAULT,
  localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1
) (
  input  logic                clk,
  input  logic                wr_en,
  input  logic [IDX_W-1:0]    wr_addr,
  input  owdq_pkg::entry_t    wr_data,
  input  logic                rd_en,
  input  logic [IDX_W-1:0]    rd_addr,
  output owdq_pkg::entry_t    rd_data
);

  owdq_pkg::entry_t mem [QUEUE_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- dv/overwrite_oldest_descriptor_queue_top_test.sv -----
// Self-checking testbench for the overwrite-oldest descriptor queue top level.
module overwrite_oldest_descriptor_queue_top_test;

  localparam int DEPTH = owdq_pkg::QUEUE_DEPTH_DEFAULT;
  localparam int CYCLE_LIMIT = 200000;
  localparam int SQUEEZE_CYCLES = 80;
  localparam int SETTLE_CYCLES = 4;

  typedef struct packed {
    owdq_pkg::op_t                opcode;
    logic [owdq_pkg::FIELD_W-1:0] topic;
    logic [owdq_pkg::FIELD_W-1:0] msg_id;
    logic [owdq_pkg::FIELD_W-1:0] msg_length;
  } req_word_t;

  typedef struct packed {
    logic                         ok;
    logic [owdq_pkg::FIELD_W-1:0] topic;
    logic [owdq_pkg::FIELD_W-1:0] msg_id;
    logic [owdq_pkg::FIELD_W-1:0] msg_length;
    logic [owdq_pkg::HELD_W-1:0]  held;
  } reply_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic cfg_wdata;

  owdq_req_if req_ch();
  owdq_rsp_if rsp_ch();

  overwrite_oldest_descriptor_queue_top dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .req       (req_ch),
    .rsp       (rsp_ch)
  );

  logic [owdq_pkg::FIELD_W-1:0] slot_topic [DEPTH];
  logic [owdq_pkg::FIELD_W-1:0] slot_id [DEPTH];
  logic [owdq_pkg::FIELD_W-1:0] slot_length [DEPTH];
  int                           oldest_slot;
  int                           free_slot;
  int                           held_count;
  logic                         keep_oldest;

  req_word_t pending_words[$];
  reply_t    expected_replies[$];
  int        words_queued;
  int        words_taken;
  int        replies_seen;
  int        mismatch_count;
  int        cycle_count;
  int        gap_left;
  int        stall_left;
  int        squeeze_req;
  int        squeeze_ack;
  bit        idle_on;

  function automatic void discard_oldest();
    slot_topic[oldest_slot] = '0;
    slot_id[oldest_slot] = '0;
    slot_length[oldest_slot] = '0;
    oldest_slot = (oldest_slot + 1) % DEPTH;
    held_count--;
  endfunction

  function automatic reply_t predict_queue_op(req_word_t w);
    reply_t r;
    int     slot;
    r = '0;
    if (w.opcode == owdq_pkg::OP_PUSH) begin
      if (w.msg_length != 0) begin
        if (held_count >= DEPTH && !keep_oldest) discard_oldest();
        if (held_count < DEPTH) begin
          slot_topic[free_slot] = w.topic;
          slot_id[free_slot] = w.msg_id;
          slot_length[free_slot] = w.msg_length;
          free_slot = (free_slot + 1) % DEPTH;
          held_count++;
          r.ok = 1'b1;
        end
      end
    end else if (held_count > 0) begin
      slot = (w.opcode == owdq_pkg::OP_PEEK_NEWEST) ? (free_slot + DEPTH - 1) % DEPTH
                                                     : oldest_slot;
      r.topic = slot_topic[slot];
      r.msg_id = slot_id[slot];
      r.msg_length = slot_length[slot];
      r.ok = 1'b1;
      if (w.opcode == owdq_pkg::OP_POP) discard_oldest();
    end
    r.held = held_count[owdq_pkg::HELD_W-1:0];
    return r;
  endfunction

  function automatic void add_word(owdq_pkg::op_t op, logic [owdq_pkg::FIELD_W-1:0] topic,
                                   logic [owdq_pkg::FIELD_W-1:0] msg_id,
                                   logic [owdq_pkg::FIELD_W-1:0] msg_length);
    req_word_t w;
    w.opcode = op;
    w.topic = topic;
    w.msg_id = msg_id;
    w.msg_length = msg_length;
    pending_words.push_back(w);
    words_queued++;
  endfunction

  function automatic logic [owdq_pkg::FIELD_W-1:0] random_length();
    int pick;
    pick = $urandom_range(0, 15);
    if (pick == 0) return '0;
    if (pick == 1) return '1;
    return owdq_pkg::FIELD_W'($urandom);
  endfunction

  // Bursts lean toward pushes or toward pops so that the queue keeps swinging
  // between full and empty.
  function automatic void add_random_words(int count);
    int             push_pct;
    int             burst;
    owdq_pkg::op_t  op;
    push_pct = 75;
    burst = 0;
    for (int n = 0; n < count; n++) begin
      if (burst == 0) begin
        burst = $urandom_range(6, 20);
        push_pct = (push_pct > 50) ? 25 : 80;
      end
      burst--;
      if ($urandom_range(1, 100) <= push_pct) op = owdq_pkg::OP_PUSH;
      else op = owdq_pkg::op_t'($urandom_range(1, 3));
      add_word(op, owdq_pkg::FIELD_W'($urandom), owdq_pkg::FIELD_W'($urandom),
               random_length());
    end
  endfunction

  task automatic write_keep_oldest(logic value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    keep_oldest = value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_until_drained();
    do @(posedge clk);
    while (!(words_taken == words_queued && replies_seen == words_queued));
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = 1'b0;
    req_ch.valid = 1'b0;
    req_ch.opcode = owdq_pkg::OP_PUSH;
    req_ch.topic = '0;
    req_ch.msg_id = '0;
    req_ch.msg_length = '0;
    rsp_ch.ready = 1'b0;
    for (int i = 0; i < DEPTH; i++) begin
      slot_topic[i] = '0;
      slot_id[i] = '0;
      slot_length[i] = '0;
    end
    oldest_slot = 0;
    free_slot = 0;
    held_count = 0;
    keep_oldest = 1'b0;
    words_queued = 0;
    mismatch_count = 0;
    squeeze_req = 0;
    idle_on = 1'b1;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    write_keep_oldest(1'b0);
    add_word(owdq_pkg::OP_PEEK_OLDEST, '1, '1, '1);
    add_word(owdq_pkg::OP_PEEK_NEWEST, '1, '1, '1);
    add_word(owdq_pkg::OP_POP, '1, '1, '1);
    add_word(owdq_pkg::OP_PUSH, '1, '1, '0);
    add_word(owdq_pkg::OP_PUSH, '1, '1, '1);
    add_word(owdq_pkg::OP_PUSH, '0, '0, 16'd1);
    add_word(owdq_pkg::OP_PEEK_OLDEST, '0, '0, '0);
    add_word(owdq_pkg::OP_PEEK_NEWEST, '0, '0, '0);
    for (int i = 0; i < DEPTH - 2; i++)
      add_word(owdq_pkg::OP_PUSH, 16'h1000 + 16'(i), 16'h2000 + 16'(i),
               16'h0100 + 16'(i));
    add_word(owdq_pkg::OP_PUSH, 16'hA5A5, 16'h5A5A, 16'h00FF);
    add_word(owdq_pkg::OP_PUSH, 16'hBEEF, 16'hCAFE, '0);
    add_word(owdq_pkg::OP_PEEK_OLDEST, '0, '0, '0);
    add_word(owdq_pkg::OP_PEEK_NEWEST, '0, '0, '0);
    add_word(owdq_pkg::OP_POP, '0, '0, '0);
    wait_until_drained();

    write_keep_oldest(1'b1);
    add_word(owdq_pkg::OP_PUSH, 16'h7FFF, 16'h8000, 16'h8000);
    add_word(owdq_pkg::OP_PUSH, 16'h0F0F, 16'hF0F0, 16'h1234);
    add_word(owdq_pkg::OP_PEEK_NEWEST, '0, '0, '0);
    add_word(owdq_pkg::OP_POP, '0, '0, '0);
    add_random_words(150);
    wait_until_drained();

    write_keep_oldest(1'b0);
    add_random_words(150);
    squeeze_req++;
    wait_until_drained();

    write_keep_oldest(1'b1);
    add_random_words(100);
    squeeze_req++;
    wait_until_drained();

    idle_on = 1'b0;
    write_keep_oldest(1'b0);
    add_random_words(120);
    wait_until_drained();

    if (mismatch_count == 0 && expected_replies.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  always @(posedge clk) begin : driver
    req_word_t w;
    if (rst) begin
      req_ch.valid <= 1'b0;
      words_taken <= 0;
      gap_left <= 0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        w.opcode = req_ch.opcode;
        w.topic = req_ch.topic;
        w.msg_id = req_ch.msg_id;
        w.msg_length = req_ch.msg_length;
        expected_replies.push_back(predict_queue_op(w));
        words_taken <= words_taken + 1;
      end
      if (!req_ch.valid || req_ch.ready) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          req_ch.valid <= 1'b0;
        end else if (pending_words.size() == 0) begin
          req_ch.valid <= 1'b0;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
          gap_left <= $urandom_range(0, 6);
          req_ch.valid <= 1'b0;
        end else begin
          w = pending_words.pop_front();
          req_ch.opcode <= w.opcode;
          req_ch.topic <= w.topic;
          req_ch.msg_id <= w.msg_id;
          req_ch.msg_length <= w.msg_length;
          req_ch.valid <= 1'b1;
        end
      end
    end
  end

  always @(posedge clk) begin : monitor
    reply_t got;
    reply_t want;
    if (rst) begin
      rsp_ch.ready <= 1'b0;
      replies_seen <= 0;
      stall_left <= 0;
      squeeze_ack <= 0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        got.ok = rsp_ch.ok;
        got.topic = rsp_ch.out_topic;
        got.msg_id = rsp_ch.out_id;
        got.msg_length = rsp_ch.out_length;
        got.held = rsp_ch.entries_held;
        replies_seen <= replies_seen + 1;
        if (expected_replies.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("Unexpected reply: ok=%0d topic=%h id=%h length=%h held=%0d",
                     got.ok, got.topic, got.msg_id, got.msg_length, got.held);
        end else begin
          want = expected_replies.pop_front();
          if (got.ok !== want.ok || got.topic !== want.topic ||
              got.msg_id !== want.msg_id || got.msg_length !== want.msg_length ||
              got.held !== want.held) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("Reply %0d mismatch: expected ok=%0d topic=%h id=%h length=%h",
                       replies_seen, want.ok, want.topic, want.msg_id, want.msg_length,
                       " held=%0d, got ok=%0d topic=%h id=%h length=%h held=%0d",
                       want.held, got.ok, got.topic, got.msg_id, got.msg_length,
                       got.held);
          end
        end
      end
      if (squeeze_req != squeeze_ack) begin
        squeeze_ack <= squeeze_req;
        stall_left <= SQUEEZE_CYCLES;
        rsp_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        rsp_ch.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        stall_left <= $urandom_range(0, 6);
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      cycle_count <= 0;
    end else begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

endmodule
